### rtl/core/encoder_count_extender_defines.svh
// ----------------------------------------------------------------------------
// Encoder count extender assertion macros
// Concurrent assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ENCODER_COUNT_EXTENDER_DEFINES_SVH
`define ENCODER_COUNT_EXTENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ece_pkg.sv
// ----------------------------------------------------------------------------
// Encoder count extender package
// Field widths, parameter defaults and item kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ece_pkg;

    localparam int KIND_BITS = 2;
    localparam int CH_BITS   = 3;
    localparam int RAW_BITS  = 8;
    localparam int POS_BITS  = 32;

    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_DATA_BITS  = 8;
    localparam int DEF_COUNT_BITS = 32;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PRIME  = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

endpackage

`default_nettype wire

### rtl/core/ece_step.sv
// ----------------------------------------------------------------------------
// Encoder count extender step unit
// Computes one channel's new baseline and accumulated count for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ece_step #(
    parameter int DATA_BITS  = 8,
    parameter int COUNT_BITS = 32
) (
    input  wire logic [ece_pkg::KIND_BITS-1:0] i_kind,
    input  wire logic [DATA_BITS-1:0]          i_raw,
    input  wire logic [DATA_BITS-1:0]          i_last_raw,
    input  wire logic [COUNT_BITS-1:0]         i_acc,
    output logic                               o_write,
    output logic [DATA_BITS-1:0]               o_last_raw,
    output logic [COUNT_BITS-1:0]              o_acc
);
    import ece_pkg::*;

    logic [DATA_BITS-1:0]  diff;
    logic [COUNT_BITS-1:0] step;

    // wrapping difference, sign-extended to the accumulator width
    assign diff = i_raw - i_last_raw;
    assign step = {{(COUNT_BITS-DATA_BITS){diff[DATA_BITS-1]}}, diff};

    always_comb begin
        o_write    = 1'b0;
        o_last_raw = i_last_raw;
        o_acc      = i_acc;
        case (i_kind)
            KIND_PRIME: begin
                o_write    = 1'b1;
                o_last_raw = i_raw;
                o_acc      = '0;
            end
            KIND_UPDATE: begin
                o_write    = 1'b1;
                o_last_raw = i_raw;
                o_acc      = i_acc + step;
            end
            default: begin
                // read and unused code: report only
                o_write = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/encoder_count_extender.sv
// ----------------------------------------------------------------------------
// Encoder count extender
// Multi-channel extension of narrow wrapping encoder counts to wide positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries kind, channel and raw count.
//   A transfer happens on a rising edge with valid high and stall low.
//   Kind prime stores the raw count as baseline and clears the position,
//   kind update adds the sign-extended wrapping delta to the position,
//   kind read only reports. Every input transfer yields one output transfer
//   (o_valid / i_stall) with the channel echoed and its position afterwards.
//   Channels at or above CHANNELS report position 0 and change nothing.
//   Each item passes the input register, then the result register, on its
//   way to o_valid. Throughput: one item per cycle while i_stall is low;
//   state is read and written in the same cycle an item moves into the
//   result register, so back-to-back items on one channel see each other's
//   updates. Receiver stall: the result register holds; an empty input
//   register takes one more item, then o_stall rises until the result drains.
//   Reset (sync, active low) clears both valids, all baselines and positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module encoder_count_extender #(
    parameter int CHANNELS   = ece_pkg::DEF_CHANNELS,
    parameter int DATA_BITS  = ece_pkg::DEF_DATA_BITS,
    parameter int COUNT_BITS = ece_pkg::DEF_COUNT_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [ece_pkg::KIND_BITS-1:0]      i_kind,
    input  wire logic [ece_pkg::CH_BITS-1:0]        i_channel,
    input  wire logic [ece_pkg::RAW_BITS-1:0]       i_raw_count,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [ece_pkg::CH_BITS-1:0]             o_channel_res,
    output logic signed [ece_pkg::POS_BITS-1:0]     o_position
);
    import ece_pkg::*;

    // only 2**CH_BITS channels can ever be addressed
    localparam int DEPTH = (CHANNELS < (1 << CH_BITS)) ? CHANNELS : (1 << CH_BITS);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // input register
    logic                 r_in_valid;
    logic [KIND_BITS-1:0] r_kind;
    logic [CH_BITS-1:0]   r_ch;
    logic [DATA_BITS-1:0] r_raw;

    // result register
    logic                 r_out_valid;
    logic [CH_BITS-1:0]   r_out_ch;
    logic [POS_BITS-1:0]  r_out_pos;

    // per-channel state
    logic [DATA_BITS-1:0]  r_last_raw [DEPTH];
    logic [COUNT_BITS-1:0] r_acc      [DEPTH];

    logic                  out_ready;
    logic                  in_take;
    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic                  step_write;
    logic [DATA_BITS-1:0]  n_last_raw;
    logic [COUNT_BITS-1:0] n_acc;
    logic [POS_BITS-1:0]   n_pos;

    // result register frees up when empty or being taken this cycle
    assign out_ready = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_take   = i_valid && !o_stall;

    assign in_range = (32'(r_ch) < CHANNELS);
    assign idx      = r_ch[IDX_W-1:0];

    ece_step #(
        .DATA_BITS  (DATA_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_kind     (r_kind),
        .i_raw      (r_raw),
        .i_last_raw (r_last_raw[idx]),
        .i_acc      (r_acc[idx]),
        .o_write    (step_write),
        .o_last_raw (n_last_raw),
        .o_acc      (n_acc)
    );

    // low bits of the accumulator; zero-extended if it is narrower
    assign n_pos = in_range ? POS_BITS'(n_acc) : '0;

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_last_raw[i] <= '0;
                r_acc[i]      <= '0;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (out_ready) begin
                r_in_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            // state commits as the item moves into the result register
            if (r_in_valid && out_ready && in_range && step_write) begin
                r_last_raw[idx] <= n_last_raw;
                r_acc[idx]      <= n_acc;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_ch   <= i_channel;
            r_raw  <= i_raw_count[DATA_BITS-1:0];
        end
        if (out_ready && r_in_valid) begin
            r_out_ch  <= r_ch;
            r_out_pos <= n_pos;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_channel_res = r_out_ch;
    assign o_position    = signed'(r_out_pos);

endmodule

`default_nettype wire

### rtl/core/ece_checker.sv
// ----------------------------------------------------------------------------
// Encoder count extender checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_count_extender_defines.svh"

module ece_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_stall,
    input wire logic [ece_pkg::KIND_BITS-1:0]      i_kind,
    input wire logic [ece_pkg::CH_BITS-1:0]        i_channel,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic [ece_pkg::CH_BITS-1:0]        o_channel_res,
    input wire logic signed [ece_pkg::POS_BITS-1:0] o_position
);
    import ece_pkg::*;

    // a stalled result holds
    `ECE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_position) && $stable(o_channel_res), "stalled result changed")

    // input stalls only when a result is pending and blocked
    `ECE_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stall without blocked result")

    // a prime that moves on to the result register unstalled reports zero for its channel
    `ECE_ASSERT_NEXT(a_prime_zero, i_clk, i_rst_n, (i_valid && !o_stall && (i_kind == KIND_PRIME)) ##1 (!o_valid || !i_stall), o_valid && (o_position == 0) && (o_channel_res == $past(i_channel, 2)), "prime result wrong")

    // reset empties the output
    `ECE_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid, "output valid after reset")

endmodule

bind encoder_count_extender ece_checker u_ece_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_kind        (i_kind),
    .i_channel     (i_channel),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_channel_res (o_channel_res),
    .o_position    (o_position)
);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Encoder count extender testbench
// Runs a short table of directed transfers, then random samples weighted
// toward well-formed update sequences, and scores every result against a
// known answer or a per-channel position tracker. Random idle bursts occur on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import ece_pkg::*;

    // Unused kind code; the block treats it as a read.
    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1175;
    localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
    localparam int QUIET_TAIL  = 150;   // final transfers run with no idling
    localparam int HOLD_AT     = 400;   // result count that starts the long hold
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_AT    = 700;   // sender waits for an empty scoreboard here
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [CH_BITS-1:0]         channel;
        logic signed [POS_BITS-1:0] position;
    } t_position_result;

    // typed = 1: the position column is the known answer for this row.
    // typed = 0: the row is scored against the position tracker.
    typedef struct packed {
        logic [KIND_BITS-1:0]       kind;
        logic [CH_BITS-1:0]         channel;
        logic [RAW_BITS-1:0]        raw;
        logic                       typed;
        logic signed [POS_BITS-1:0] position;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{KIND_READ,   3'd0, 8'h00, 1'b1,    0},  // state after reset
        '{KIND_READ,   3'd6, 8'hFF, 1'b1,    0},
        '{KIND_UPDATE, 3'd7, 8'hFF, 1'b1,   -1},  // update with no prime, baseline 0
        '{KIND_SPARE,  3'd7, 8'hAA, 1'b1,   -1},  // spare kind reads only
        '{KIND_PRIME,  3'd1, 8'h80, 1'b1,    0},
        '{KIND_UPDATE, 3'd1, 8'h00, 1'b1, -128},  // half-range step counts negative
        '{KIND_UPDATE, 3'd1, 8'h7F, 1'b1,   -1},
        '{KIND_PRIME,  3'd2, 8'hFF, 1'b1,    0},
        '{KIND_UPDATE, 3'd2, 8'h00, 1'b1,    1},  // forward through the raw wrap
        '{KIND_UPDATE, 3'd2, 8'hFF, 1'b1,    0},  // and back
        '{KIND_PRIME,  3'd3, 8'h00, 1'b1,    0},
        '{KIND_UPDATE, 3'd3, 8'h7F, 1'b1,  127},  // largest forward step
        '{KIND_UPDATE, 3'd3, 8'hFE, 1'b1,  254},
        '{KIND_UPDATE, 3'd3, 8'h7D, 1'b0,    0},
        '{KIND_UPDATE, 3'd3, 8'hFC, 1'b0,    0},
        '{KIND_UPDATE, 3'd3, 8'h7C, 1'b0,    0},
        '{KIND_PRIME,  3'd7, 8'h55, 1'b1,    0},  // prime clears the position
        '{KIND_UPDATE, 3'd7, 8'h55, 1'b1,    0},  // zero step
        '{KIND_READ,   3'd3, 8'h00, 1'b0,    0},
        '{KIND_UPDATE, 3'd4, 8'h01, 1'b0,    0},
        '{KIND_UPDATE, 3'd5, 8'h80, 1'b1, -128},
        '{KIND_UPDATE, 3'd4, 8'h01, 1'b0,    0},
        '{KIND_UPDATE, 3'd4, 8'h02, 1'b0,    0},
        '{KIND_SPARE,  3'd0, 8'hFF, 1'b1,    0},
        '{KIND_READ,   3'd7, 8'h00, 1'b1,    0}
    };

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic [KIND_BITS-1:0]       i_kind      = '0;
    logic [CH_BITS-1:0]         i_channel   = '0;
    logic [RAW_BITS-1:0]        i_raw_count = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [CH_BITS-1:0]         o_channel_res;
    logic signed [POS_BITS-1:0] o_position;

    // Tracker state: baseline raw count and extended position per channel.
    logic [RAW_BITS-1:0]        baseline_raw [DEF_CHANNELS];
    logic signed [POS_BITS-1:0] position_acc [DEF_CHANNELS];

    t_position_result pending_positions [$];
    int               error_count  = 0;
    int               results_seen = 0;

    encoder_count_extender uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_channel     (i_channel),
        .i_raw_count   (i_raw_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_channel_res (o_channel_res),
        .o_position    (o_position)
    );

    always #10 i_clk = ~i_clk;

    // Applies one transfer to the tracker and returns the channel's position.
    function automatic logic signed [POS_BITS-1:0] advance_position(
        input logic [KIND_BITS-1:0] kind,
        input logic [CH_BITS-1:0]   ch,
        input logic [RAW_BITS-1:0]  raw
    );
        logic [RAW_BITS-1:0]        delta;
        logic signed [POS_BITS-1:0] step;
        if (ch >= DEF_CHANNELS)
            return '0;
        case (kind)
            KIND_PRIME: begin
                baseline_raw[ch] = raw;
                position_acc[ch] = '0;
            end
            KIND_UPDATE: begin
                // Raw difference wraps at the raw width; its top bit is the sign.
                delta            = raw - baseline_raw[ch];
                step             = {{(POS_BITS-RAW_BITS){delta[RAW_BITS-1]}}, delta};
                position_acc[ch] = position_acc[ch] + step;
                baseline_raw[ch] = raw;
            end
            default: ;  // read and the spare code leave state alone
        endcase
        return position_acc[ch];
    endfunction

    // Offers one transfer and holds it until accepted, then logs what the
    // result must be. Returns at the accepting clock edge.
    task automatic send_sample(
        input logic [KIND_BITS-1:0]       kind,
        input logic [CH_BITS-1:0]         ch,
        input logic [RAW_BITS-1:0]        raw,
        input logic                       typed,
        input logic signed [POS_BITS-1:0] typed_pos
    );
        logic signed [POS_BITS-1:0] tracked;
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_channel   <= ch;
        i_raw_count <= raw;
        do @(posedge i_clk); while (o_stall);
        tracked = advance_position(kind, ch, raw);
        pending_positions.push_back('{ch, typed ? typed_pos : tracked});
    endtask

    // Sender: directed table, then random transfers.
    initial begin
        logic [KIND_BITS-1:0] kind;
        logic [CH_BITS-1:0]   ch;
        logic [RAW_BITS-1:0]  raw;
        int                   sel;
        for (int c = 0; c < DEF_CHANNELS; c++) begin
            baseline_raw[c] = '0;
            position_acc[c] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_TOTAL; n++) begin
            // Two points where the sender stops and lets the pipeline drain.
            if (n == N_DIRECTED || n == DRAIN_AT) begin
                i_valid <= 1'b0;
                while (pending_positions.size() != 0) @(posedge i_clk);
            end else if (n < N_TOTAL - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end

            if (n < N_DIRECTED) begin
                send_sample(DIRECTED_ROWS[n].kind, DIRECTED_ROWS[n].channel,
                            DIRECTED_ROWS[n].raw, DIRECTED_ROWS[n].typed,
                            DIRECTED_ROWS[n].position);
            end else begin
                sel = $urandom_range(0, 99);
                ch  = CH_BITS'($urandom_range(0, DEF_CHANNELS - 1));
                raw = RAW_BITS'($urandom);
                if (sel < 8)       kind = KIND_PRIME;
                else if (sel < 82) kind = KIND_UPDATE;
                else if (sel < 94) kind = KIND_READ;
                else               kind = KIND_SPARE;
                // Half of the updates step from the current baseline: small moves
                // either way, or steps right at the sign boundary.
                if (kind == KIND_UPDATE && $urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 3))
                        0:       raw = baseline_raw[ch] + RAW_BITS'($urandom_range(1, 4));
                        1:       raw = baseline_raw[ch] - RAW_BITS'($urandom_range(1, 4));
                        2:       raw = baseline_raw[ch] + 8'd127;
                        default: raw = baseline_raw[ch] + 8'd128;
                    endcase
                end
                send_sample(kind, ch, raw, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: scores each result transfer and drives the stall.
    initial begin
        t_position_result want;
        int               stall_left = 0;
        bit               hold_done  = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_positions.size() == 0) begin
                    $error("unexpected result: channel_res %0d position %0d",
                           o_channel_res, o_position);
                    error_count++;
                end else begin
                    want = pending_positions.pop_front();
                    if (o_channel_res !== want.channel) begin
                        $error("channel_res: expected %0d, got %0d",
                               want.channel, o_channel_res);
                        error_count++;
                    end
                    if (o_position !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, o_position);
                        error_count++;
                    end
                end
            end

            // One long hold so the block backs up and stalls its input, random
            // short bursts otherwise, nothing in the final stretch.
            if (stall_left == 0) begin
                if (!hold_done && results_seen >= HOLD_AT) begin
                    stall_left = HOLD_CYCLES;
                    hold_done  = 1;
                end else if (results_seen < N_TOTAL - QUIET_TAIL
                             && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 3);
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog, well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
